// ===== src/sha1md_pkg.sv =====
// Shared constants and types for the SHA-1 message digest block.
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [6:0] LAST_ADD    = 7'd4;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [4:0] LAST_DIGEST = 5'd19;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

// ===== src/sha1_message_digest.sv =====
// SHA-1 message digest: byte-wide message in, 20 digest bytes out.
`default_nettype none

// Takes one message byte per request and returns the SHA-1 digest as 20 bytes,
// most significant first, with digest_last on the final byte. A byte that does
// not complete a 64-byte block is taken without stalling the input. The byte that
// completes a block starts the compression: 80 rounds on the single round adder,
// one per cycle, then a fold of the working words into the chaining words, and
// that request holds the input until the fold is done. A request with
// end_of_message then appends padding one byte per cycle up to the end of the
// block, with one or two further compressions, and presents the digest bytes
// one per cycle as the output side takes them. The input is stalled
// throughout. After the last digest byte the block starts a new message.
module sha1_message_digest (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       byte_present,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] digest_byte,
  output logic            digest_last
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_ADD,
    S_PAD,
    S_OUT
  } state_t;

  state_t       state;
  word_t        h     [5];
  word_t        wk    [5];
  word_t        sched [16];
  logic [23:0]  acc;
  logic [5:0]   pos;
  logic [60:0]  count;
  logic [6:0]   rnd;
  logic [4:0]   out_cnt;
  logic         end_pend;
  logic         pad_act;
  logic         first;
  logic         len_ok;

  logic         in_acc;
  logic         put_en;
  logic [7:0]   put_val;
  logic [7:0]   pad_val;
  logic [7:0]   len_val;
  logic [63:0]  bit_len;
  logic [5:0]   len_sh;
  word_t        w_cur;
  word_t        f_val;
  word_t        k_val;
  word_t        t_val;

  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = (state == S_OUT);
  assign digest_byte = h[0][31:24];
  assign digest_last = (out_cnt == LAST_DIGEST);

  assign bit_len = {count, 3'b000};
  assign len_sh  = {3'(3'd7 - pos[2:0]), 3'b000};
  assign len_val = 8'(bit_len >> len_sh);

  always_comb begin
    if (first) begin
      pad_val = PAD_BYTE;
    end else if (len_ok && pos >= LEN_POS) begin
      pad_val = len_val;
    end else begin
      pad_val = 8'h00;
    end
  end

  assign put_en  = (in_acc && byte_present) || (state == S_PAD);
  assign put_val = (state == S_PAD) ? pad_val : data_byte;

  always_comb begin
    if (rnd < 7'd16) begin
      w_cur = sched[0];
    end else begin
      w_cur = rotl(sched[13] ^ sched[8] ^ sched[2] ^ sched[0], 1);
    end
    if (rnd < 7'd20) begin
      f_val = (wk[1] & wk[2]) | (~wk[1] & wk[3]);
      k_val = K_0;
    end else if (rnd < 7'd40) begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K_1;
    end else if (rnd < 7'd60) begin
      f_val = (wk[1] & wk[2]) | (wk[1] & wk[3]) | (wk[2] & wk[3]);
      k_val = K_2;
    end else begin
      f_val = wk[1] ^ wk[2] ^ wk[3];
      k_val = K_3;
    end
    t_val = rotl(wk[0], 5) + f_val + wk[4] + k_val + w_cur;
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      if (pos[1:0] == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          sched[i] <= sched[i + 1];
        end
        sched[15] <= {acc, put_val};
      end else begin
        acc <= {acc[15:0], put_val};
      end
    end

    if (rst) begin
      state    <= S_IDLE;
      h        <= H_INIT;
      pos      <= '0;
      count    <= '0;
      rnd      <= '0;
      out_cnt  <= '0;
      end_pend <= 1'b0;
      pad_act  <= 1'b0;
      first    <= 1'b0;
      len_ok   <= 1'b0;
    end else begin
      if (put_en) begin
        pos <= pos + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (byte_present) begin
              count <= count + 61'd1;
              if (pos == LAST_POS) begin
                state    <= S_ROUND;
                wk       <= h;
                rnd      <= '0;
                end_pend <= end_of_message;
              end else if (end_of_message) begin
                state   <= S_PAD;
                first   <= 1'b1;
                pad_act <= 1'b1;
              end
            end else if (end_of_message) begin
              state   <= S_PAD;
              first   <= 1'b1;
              pad_act <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            sched[i] <= sched[i + 1];
          end
          sched[15] <= w_cur;
          wk[4] <= wk[3];
          wk[3] <= wk[2];
          wk[2] <= rotl(wk[1], 30);
          wk[1] <= wk[0];
          wk[0] <= t_val;
          if (rnd == LAST_ROUND) begin
            state <= S_ADD;
            rnd   <= '0;
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 4; i++) begin
            h[i]  <= h[i + 1];
            wk[i] <= wk[i + 1];
          end
          h[4] <= h[0] + wk[0];
          if (rnd == LAST_ADD) begin
            rnd <= '0;
            if (pad_act) begin
              if (len_ok) begin
                state   <= S_OUT;
                out_cnt <= '0;
              end else begin
                state  <= S_PAD;
                len_ok <= 1'b1;
              end
            end else if (end_pend) begin
              state    <= S_PAD;
              first    <= 1'b1;
              pad_act  <= 1'b1;
              end_pend <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            rnd <= rnd + 7'd1;
          end
        end
        S_PAD: begin
          first <= 1'b0;
          if (first) begin
            len_ok <= (pos < LEN_POS);
          end
          if (pos == LAST_POS) begin
            state <= S_ROUND;
            wk    <= h;
            rnd   <= '0;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_cnt == LAST_DIGEST) begin
              state   <= S_IDLE;
              h       <= H_INIT;
              count   <= '0;
              pos     <= '0;
              pad_act <= 1'b0;
              len_ok  <= 1'b0;
              out_cnt <= '0;
            end else begin
              for (int i = 0; i < 4; i++) begin
                h[i] <= {h[i][23:0], h[i + 1][31:24]};
              end
              h[4]    <= {h[4][23:0], 8'h00};
              out_cnt <= out_cnt + 5'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
